// ===== sv/staggered_grid_midpoint_advection_core_macros.svh =====
// assertion macros for the staggered grid midpoint advection core
// used by the top level rtl file of the core, no other dependencies
`ifndef STAGGERED_GRID_MIDPOINT_ADVECTION_CORE_MACROS_SVH
`define STAGGERED_GRID_MIDPOINT_ADVECTION_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SGMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SGMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SGMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SGMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/sgma_pkg.sv =====
// shared constants, codes and arithmetic helpers of the advection core
// no dependencies
`default_nettype none
package sgma_pkg;
	localparam int DEF_MAX_COLS = 64;
	localparam int DEF_MAX_ROWS = 64;
	localparam int KIND_W = 2;
	localparam int FACE_W = 7;
	localparam int DATA_W = 32;
	localparam int FRAC_W = 16;
	localparam int CFG_W = 31;
	localparam int CFG_IDX_W = 3;
	localparam int GRID_W = 7;
	localparam int IDX_W = 18;

	localparam logic [KIND_W-1:0] KIND_LOAD_H = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD_V = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ADVECT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_CELL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 3'd4;

	localparam logic [CFG_W-1:0] RST_CELL_SIZE = 31'd65536;
	localparam logic [CFG_W-1:0] RST_INV_CELL = 31'd65536;
	localparam logic [CFG_W-1:0] RST_TIME_STEP = 31'd655;
	localparam logic [GRID_W-1:0] RST_GRID = 7'd64;

	localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
		if (v > S32_MAX) begin
			return 32'sh7fffffff;
		end else if (v < S32_MIN) begin
			return 32'sh80000000;
		end else begin
			return v[DATA_W-1:0];
		end
	endfunction

	function automatic logic [IDX_W-1:0] clamp_idx(input logic signed [IDX_W-1:0] v,
			input logic signed [IDX_W-1:0] hi);
		if (v < 0) begin
			return '0;
		end else if (v > hi) begin
			return hi;
		end else begin
			return v;
		end
	endfunction
endpackage
`default_nettype wire

// ===== sv/sgma_store.sv =====
// one face velocity store split into four parity banks, one read per bank a cycle
// depends on sgma_pkg
`default_nettype none
module sgma_store #(
	parameter int MAX_COLS = sgma_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = sgma_pkg::DEF_MAX_ROWS,
	localparam int CW = $clog2(MAX_COLS + 1),
	localparam int RW = $clog2(MAX_ROWS + 1)
) (
	input logic clk,
	input logic we,
	input logic [CW-1:0] wcol,
	input logic [RW-1:0] wrow,
	input logic signed [sgma_pkg::DATA_W-1:0] wdata,
	input logic [CW-1:0] ia,
	input logic [CW-1:0] ib,
	input logic [RW-1:0] ja,
	input logic [RW-1:0] jb,
	output logic signed [sgma_pkg::DATA_W-1:0] c00,
	output logic signed [sgma_pkg::DATA_W-1:0] c10,
	output logic signed [sgma_pkg::DATA_W-1:0] c01,
	output logic signed [sgma_pkg::DATA_W-1:0] c11
);
	import sgma_pkg::*;

	localparam int BANK_W = MAX_COLS / 2 + 1;
	localparam int BANK_H = MAX_ROWS / 2 + 1;
	localparam int BANK_DEPTH = BANK_W * BANK_H;
	localparam int AW = $clog2(BANK_DEPTH);
	localparam logic [AW-1:0] BANK_W_A = AW'(BANK_W);

	logic [1:0] wbank;
	logic [AW-1:0] waddr;
	logic signed [DATA_W-1:0] rdat [4];
	logic ia0_q, ib0_q, ja0_q, jb0_q;

	assign wbank = {wrow[0], wcol[0]};
	assign waddr = AW'(wrow[RW-1:1]) * BANK_W_A + AW'(wcol[CW-1:1]);

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic PC = 1'(b % 2);
		localparam logic PR = 1'(b / 2);
		logic signed [DATA_W-1:0] mem [BANK_DEPTH];
		logic [CW-1:0] rc;
		logic [RW-1:0] rr;
		logic [AW-1:0] ra;

		always_comb begin
			rc = (ia[0] == PC) ? ia : ib;
			rr = (ja[0] == PR) ? ja : jb;
			ra = AW'(rr[RW-1:1]) * BANK_W_A + AW'(rc[CW-1:1]);
		end

		always_ff @(posedge clk) begin
			if (we && wbank == 2'(b)) begin
				mem[waddr] <= wdata;
			end
			rdat[b] <= mem[ra];
		end
	end

	always_ff @(posedge clk) begin
		ia0_q <= ia[0];
		ib0_q <= ib[0];
		ja0_q <= ja[0];
		jb0_q <= jb[0];
	end

	assign c00 = rdat[{ja0_q, ia0_q}];
	assign c10 = rdat[{ja0_q, ib0_q}];
	assign c01 = rdat[{jb0_q, ia0_q}];
	assign c11 = rdat[{jb0_q, ib0_q}];
endmodule
`default_nettype wire

// ===== sv/sgma_interp.sv =====
// four stage bilinear interpolation of a 2x2 corner set, x first then y
// depends on sgma_pkg
`default_nettype none
module sgma_interp (
	input logic clk,
	input logic signed [sgma_pkg::DATA_W-1:0] c00,
	input logic signed [sgma_pkg::DATA_W-1:0] c10,
	input logic signed [sgma_pkg::DATA_W-1:0] c01,
	input logic signed [sgma_pkg::DATA_W-1:0] c11,
	input logic [sgma_pkg::FRAC_W-1:0] fx,
	input logic [sgma_pkg::FRAC_W-1:0] fy,
	output logic signed [sgma_pkg::DATA_W-1:0] smp
);
	import sgma_pkg::*;

	localparam int DW = DATA_W + 1;
	localparam int PW = DATA_W + FRAC_W + 2;

	logic signed [DW-1:0] d0, d1, dy;
	logic signed [PW-1:0] t0, t1, t2;
	logic signed [DATA_W-1:0] base0_s1, base1_s1, r0_s2, r1_s2, r0_s3;
	logic signed [PW-1:0] p0_s1, p1_s1, p_s3;
	logic [FRAC_W-1:0] fy_s1, fy_s2;

	always_comb begin
		d0 = DW'(c10) - DW'(c00);
		d1 = DW'(c11) - DW'(c01);
		t0 = PW'(base0_s1) + (p0_s1 >>> FRAC_W);
		t1 = PW'(base1_s1) + (p1_s1 >>> FRAC_W);
		dy = DW'(r1_s2) - DW'(r0_s2);
		t2 = PW'(r0_s3) + (p_s3 >>> FRAC_W);
	end

	always_ff @(posedge clk) begin
		base0_s1 <= c00;
		base1_s1 <= c01;
		p0_s1 <= $signed({1'b0, fx}) * d0;
		p1_s1 <= $signed({1'b0, fx}) * d1;
		fy_s1 <= fy;
		r0_s2 <= t0[DATA_W-1:0];
		r1_s2 <= t1[DATA_W-1:0];
		fy_s2 <= fy_s1;
		r0_s3 <= r0_s2;
		p_s3 <= $signed({1'b0, fy_s2}) * dy;
		smp <= t2[DATA_W-1:0];
	end
endmodule
`default_nettype wire

// ===== sv/staggered_grid_midpoint_advection_core.sv =====
// top level: command port, configuration registers, an eleven stage sampling ring
// depends on sgma_pkg, sgma_store, sgma_interp and the assertion macro header
//
// usage
// items enter on start while busy is low; kind selects a face load (horizontal or
// vertical) or a particle advect. loads give no result. each advect gives one beat
// on new_x/new_y, marked by done for exactly one cycle; results leave in acceptance
// order and cannot be held off. an advect runs twice through the ring (first
// sample, then midpoint sample); its second pass takes the ring entry, so busy is
// high for that one cycle. a new advect can enter while earlier ones are still in
// the ring. a load is written at once unless an earlier advect still has to read
// its midpoint corners; it then waits in a holding register with busy high.
// time step and inverse cell size writes take effect at once; cell size and grid
// size writes reach the derived clamp limits through registers. reset clears the
// ring control, the holding flag and done, and loads the register defaults; the
// velocity stores are not cleared and must be loaded before use.
`default_nettype none
`include "staggered_grid_midpoint_advection_core_macros.svh"
module staggered_grid_midpoint_advection_core #(
	parameter int MAX_COLS = sgma_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = sgma_pkg::DEF_MAX_ROWS
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [sgma_pkg::KIND_W-1:0] kind,
	input logic [sgma_pkg::FACE_W-1:0] face_col,
	input logic [sgma_pkg::FACE_W-1:0] face_row,
	input logic signed [sgma_pkg::DATA_W-1:0] face_velocity,
	input logic signed [sgma_pkg::DATA_W-1:0] pos_x,
	input logic signed [sgma_pkg::DATA_W-1:0] pos_y,
	input logic cfg_we,
	input logic [sgma_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [sgma_pkg::CFG_W-1:0] cfg_data,
	output logic done,
	output logic signed [sgma_pkg::DATA_W-1:0] new_x,
	output logic signed [sgma_pkg::DATA_W-1:0] new_y
);
	import sgma_pkg::*;

	localparam int CW = $clog2(MAX_COLS + 1);
	localparam int RW = $clog2(MAX_ROWS + 1);
	localparam int NSTG = 11;
	localparam int RD_STG = 4;

	typedef struct packed {
		logic vld;
		logic rnd;
	} ctl_t;

	logic [CFG_W-1:0] cs_q, inv_q, dt_q;
	logic [GRID_W-1:0] cols_q, rows_q;
	logic [CW-1:0] nx_q;
	logic [RW-1:0] ny_q;
	logic signed [DATA_W-1:0] lo_q, hix_q, hiy_q;
	logic [CW:0] n2x;
	logic [RW:0] n2y;
	logic [CW+CFG_W:0] phx_full, hsx;
	logic [RW+CFG_W:0] phy_full, hsy;

	ctl_t ctl_q [1:NSTG];
	logic signed [DATA_W-1:0] ox_q [1:NSTG];
	logic signed [DATA_W-1:0] oy_q [1:NSTG];

	logic signed [DATA_W-1:0] cx_s1, cy_s1, gx_s3, gy_s3, mx_s11, my_s11;
	logic signed [63:0] px_s2, py_s2, pmx_s10, pmy_s10;
	logic [CW-1:0] iah_s4, ibh_s4, iav_s4, ibv_s4;
	logic [RW-1:0] jah_s4, jbh_s4, jav_s4, jbv_s4;
	logic [FRAC_W-1:0] fxh_s4, fyh_s4, fxv_s4, fyv_s4, fxh_s5, fyh_s5, fxv_s5, fyv_s5;
	logic signed [DATA_W-1:0] u_smp, v_smp;
	logic signed [DATA_W-1:0] h00, h10, h01, h11, v00, v10, v01, v11;

	logic pend_q, pend_v_q;
	logic [CW-1:0] pend_col_q;
	logic [RW-1:0] pend_row_q;
	logic signed [DATA_W-1:0] pend_dat_q;

	logic rec, acc, adv, load_ok, pre_read, we_h, we_v;
	logic [CW-1:0] wcol;
	logic [RW-1:0] wrow;
	logic signed [DATA_W-1:0] wdat;
	logic signed [32:0] phx, phy, pvx, pvy;
	logic signed [IDX_W-1:0] ihl, jhl, ivl, jvl, imh, jmh, imv, jmv, one_i;
	logic signed [63:0] shx, shy, smx, smy;
	logic signed [DATA_W-1:0] rx, ry;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q <= RST_CELL_SIZE;
			inv_q <= RST_INV_CELL;
			dt_q <= RST_TIME_STEP;
			cols_q <= RST_GRID;
			rows_q <= RST_GRID;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CELL_SIZE: cs_q <= cfg_data;
				REG_INV_CELL: inv_q <= cfg_data;
				REG_TIME_STEP: dt_q <= cfg_data;
				REG_GRID_COLS: cols_q <= cfg_data[GRID_W-1:0];
				REG_GRID_ROWS: rows_q <= cfg_data[GRID_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// derived grid limits
	always_comb begin
		n2x = {nx_q, 1'b0} - (CW+1)'(1);
		n2y = {ny_q, 1'b0} - (RW+1)'(1);
		phx_full = n2x * cs_q;
		phy_full = n2y * cs_q;
		hsx = phx_full >> 1;
		hsy = phy_full >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q <= CW'(1);
			ny_q <= RW'(1);
			lo_q <= '0;
			hix_q <= '0;
			hiy_q <= '0;
		end else begin
			if (cols_q == '0) begin
				nx_q <= CW'(1);
			end else if (int'(cols_q) > MAX_COLS) begin
				nx_q <= CW'(MAX_COLS);
			end else begin
				nx_q <= CW'(cols_q);
			end
			if (rows_q == '0) begin
				ny_q <= RW'(1);
			end else if (int'(rows_q) > MAX_ROWS) begin
				ny_q <= RW'(MAX_ROWS);
			end else begin
				ny_q <= RW'(rows_q);
			end
			lo_q <= $signed({2'b00, cs_q[CFG_W-1:1]});
			if (hsx > (CW+CFG_W+1)'(32'h7fffffff)) begin
				hix_q <= 32'sh7fffffff;
			end else begin
				hix_q <= DATA_W'(hsx);
			end
			if (hsy > (RW+CFG_W+1)'(32'h7fffffff)) begin
				hiy_q <= 32'sh7fffffff;
			end else begin
				hiy_q <= DATA_W'(hsy);
			end
		end
	end

	// handshake and store write path
	always_comb begin
		rec = ctl_q[NSTG].vld && !ctl_q[NSTG].rnd;
		busy = pend_q || rec;
		acc = start && !busy;
		adv = acc && kind == KIND_ADVECT;
		load_ok = acc && (kind == KIND_LOAD_H || kind == KIND_LOAD_V)
			&& int'(face_col) <= MAX_COLS && int'(face_row) <= MAX_ROWS;
		pre_read = 1'b0;
		for (int k = 1; k <= NSTG; k++) begin
			if (ctl_q[k].vld && (!ctl_q[k].rnd || k <= RD_STG)) begin
				pre_read = 1'b1;
			end
		end
		if (pend_q) begin
			wcol = pend_col_q;
			wrow = pend_row_q;
			wdat = pend_dat_q;
			we_h = !pre_read && !pend_v_q;
			we_v = !pre_read && pend_v_q;
		end else begin
			wcol = CW'(face_col);
			wrow = RW'(face_row);
			wdat = face_velocity;
			we_h = load_ok && !pre_read && kind == KIND_LOAD_H;
			we_v = load_ok && !pre_read && kind == KIND_LOAD_V;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (load_ok && pre_read) begin
			pend_q <= 1'b1;
		end else if (pend_q && !pre_read) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			pend_v_q <= kind == KIND_LOAD_V;
			pend_col_q <= CW'(face_col);
			pend_row_q <= RW'(face_row);
			pend_dat_q <= face_velocity;
		end
	end

	// ring control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NSTG; k++) begin
				ctl_q[k] <= '0;
			end
			done <= 1'b0;
		end else begin
			ctl_q[1].vld <= rec || adv;
			ctl_q[1].rnd <= rec;
			for (int k = 2; k <= NSTG; k++) begin
				ctl_q[k] <= ctl_q[k-1];
			end
			done <= ctl_q[NSTG].vld && ctl_q[NSTG].rnd;
		end
	end

	// index and fraction of each sample
	always_comb begin
		one_i = $signed(IDX_W'(1));
		phx = 33'(gx_s3);
		phy = 33'(gy_s3) - 33'sd32768;
		pvx = 33'(gx_s3) - 33'sd32768;
		pvy = 33'(gy_s3);
		ihl = IDX_W'(phx >>> FRAC_W);
		jhl = IDX_W'(phy >>> FRAC_W);
		ivl = IDX_W'(pvx >>> FRAC_W);
		jvl = IDX_W'(pvy >>> FRAC_W);
		imh = $signed(IDX_W'(nx_q));
		jmh = $signed(IDX_W'(ny_q)) - one_i;
		imv = $signed(IDX_W'(nx_q)) - one_i;
		jmv = $signed(IDX_W'(ny_q));
	end

	// position update
	always_comb begin
		shx = ctl_q[10].rnd ? (pmx_s10 >>> 16) : (pmx_s10 >>> 17);
		shy = ctl_q[10].rnd ? (pmy_s10 >>> 16) : (pmy_s10 >>> 17);
		smx = 64'(ox_q[10]) + shx;
		smy = 64'(oy_q[10]) + shy;
		rx = mx_s11;
		ry = my_s11;
		if (rx > hix_q) begin
			rx = hix_q;
		end
		if (rx < lo_q) begin
			rx = lo_q;
		end
		if (ry > hiy_q) begin
			ry = hiy_q;
		end
		if (ry < lo_q) begin
			ry = lo_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rec) begin
			cx_s1 <= mx_s11;
			cy_s1 <= my_s11;
			ox_q[1] <= ox_q[NSTG];
			oy_q[1] <= oy_q[NSTG];
		end else begin
			cx_s1 <= pos_x;
			cy_s1 <= pos_y;
			ox_q[1] <= pos_x;
			oy_q[1] <= pos_y;
		end
		for (int k = 2; k <= NSTG; k++) begin
			ox_q[k] <= ox_q[k-1];
			oy_q[k] <= oy_q[k-1];
		end
		px_s2 <= $signed({1'b0, inv_q}) * cx_s1;
		py_s2 <= $signed({1'b0, inv_q}) * cy_s1;
		gx_s3 <= sat32(px_s2 >>> FRAC_W);
		gy_s3 <= sat32(py_s2 >>> FRAC_W);
		iah_s4 <= CW'(clamp_idx(ihl, imh));
		ibh_s4 <= CW'(clamp_idx(ihl + one_i, imh));
		jah_s4 <= RW'(clamp_idx(jhl, jmh));
		jbh_s4 <= RW'(clamp_idx(jhl + one_i, jmh));
		iav_s4 <= CW'(clamp_idx(ivl, imv));
		ibv_s4 <= CW'(clamp_idx(ivl + one_i, imv));
		jav_s4 <= RW'(clamp_idx(jvl, jmv));
		jbv_s4 <= RW'(clamp_idx(jvl + one_i, jmv));
		fxh_s4 <= phx[FRAC_W-1:0];
		fyh_s4 <= phy[FRAC_W-1:0];
		fxv_s4 <= pvx[FRAC_W-1:0];
		fyv_s4 <= pvy[FRAC_W-1:0];
		fxh_s5 <= fxh_s4;
		fyh_s5 <= fyh_s4;
		fxv_s5 <= fxv_s4;
		fyv_s5 <= fyv_s4;
		pmx_s10 <= $signed({1'b0, dt_q}) * u_smp;
		pmy_s10 <= $signed({1'b0, dt_q}) * v_smp;
		mx_s11 <= sat32(smx);
		my_s11 <= sat32(smy);
		new_x <= rx;
		new_y <= ry;
	end

	sgma_store #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_store_h (
		.clk(clk),
		.we(we_h),
		.wcol(wcol),
		.wrow(wrow),
		.wdata(wdat),
		.ia(iah_s4),
		.ib(ibh_s4),
		.ja(jah_s4),
		.jb(jbh_s4),
		.c00(h00),
		.c10(h10),
		.c01(h01),
		.c11(h11)
	);

	sgma_store #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_store_v (
		.clk(clk),
		.we(we_v),
		.wcol(wcol),
		.wrow(wrow),
		.wdata(wdat),
		.ia(iav_s4),
		.ib(ibv_s4),
		.ja(jav_s4),
		.jb(jbv_s4),
		.c00(v00),
		.c10(v10),
		.c01(v01),
		.c11(v11)
	);

	sgma_interp u_interp_h (
		.clk(clk),
		.c00(h00),
		.c10(h10),
		.c01(h01),
		.c11(h11),
		.fx(fxh_s5),
		.fy(fyh_s5),
		.smp(u_smp)
	);

	sgma_interp u_interp_v (
		.clk(clk),
		.c00(v00),
		.c10(v10),
		.c01(v01),
		.c11(v11),
		.fx(fxv_s5),
		.fy(fyv_s5),
		.smp(v_smp)
	);

	`SGMA_ASSERT_NXT(a_adv_enters, clk, arst_n, adv, ctl_q[1].vld && !ctl_q[1].rnd, "advect beat lost at ring entry")
	`SGMA_ASSERT_NXT(a_pend_drains, clk, arst_n, pend_q && !pre_read, !pend_q, "held load not written")
	`SGMA_ASSERT_NXT(a_done_follows, clk, arst_n, ctl_q[NSTG].vld && ctl_q[NSTG].rnd, done, "second pass gave no result")
endmodule
`default_nettype wire
